/* sv/tag_fifo_with_cancel_top_assert.svh */
// Assertion macros for the tag queue top level.
// Included by tag_fifo_with_cancel_top.sv; expects clk and rst_n in scope.
`ifndef TAG_FIFO_WITH_CANCEL_TOP_ASSERT_SVH
`define TAG_FIFO_WITH_CANCEL_TOP_ASSERT_SVH

// same-cycle implication
`define TFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/tfc_pkg.sv */
// Shared types and constants for the tag queue with cancel.
// No dependencies; imported by tfc_cell and the top level.
`timescale 1ns / 1ps
package tfc_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int TAG_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_DROP   = 3'd2,
    OP_REMOVE = 3'd3,
    OP_READ   = 3'd4,
    OP_FLUSH  = 3'd5
  } tfc_op_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOEFFECT = 2'd1,
    ST_FULL     = 2'd2,
    ST_RANGE    = 2'd3
  } tfc_status_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic remove;
  } tfc_cmd_t;

endpackage

/* sv/tag_fifo_with_cancel_top.sv */
// Tag queue with cancel: top level with control, count and output snapshot.
// Depends on tfc_pkg, tfc_cell and tag_fifo_with_cancel_top_assert.svh.
`timescale 1ns / 1ps
// A request is taken on every cycle that start is high; busy stays low, so one
// request per clock is sustained. The result appears on the out_ ports at the
// clock edge after the accepting edge, marked by out_valid for exactly one cycle,
// and must be captured then. The row of cells updates at the accepting edge,
// with the remove search rippling through the row; the next edge registers
// the snapshot of front, back, read tag and count into the output stage.
module tag_fifo_with_cancel_top
  import tfc_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int TAG_WIDTH = TAG_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_tag,
  input  logic [3:0]  in_position,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_read_tag,
  output logic [31:0] out_front_tag,
  output logic [31:0] out_back_tag,
  output logic [4:0]  out_occupancy,
  output logic        out_is_empty
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 4) ? CW : 4;

  `include "tag_fifo_with_cancel_top_assert.svh"

  logic                 accept;
  tfc_op_t              op;
  logic [TAG_WIDTH-1:0] req_tag;
  logic                 tag_nz;
  logic                 full;
  logic                 empty;
  logic                 pos_ok;
  tfc_cmd_t             cmd;
  tfc_status_t          status_nxt;

  logic [CW-1:0]        count_r;
  logic [CW-1:0]        count_nxt;

  logic                 v1_r;
  tfc_status_t          status1_r;
  logic                 rdok1_r;
  logic [PW-1:0]        pos1_r;

  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic [31:0]          out_read_tag_r;
  logic [31:0]          out_front_tag_r;
  logic [31:0]          out_back_tag_r;
  logic [4:0]           out_occupancy_r;
  logic                 out_is_empty_r;

  logic [TAG_WIDTH-1:0] cell_tag  [DEPTH];
  logic [TAG_WIDTH-1:0] back_part [DEPTH];
  logic [TAG_WIDTH-1:0] read_part [DEPTH];
  logic                 hit [DEPTH+1];
  logic [TAG_WIDTH-1:0] back_or;
  logic [TAG_WIDTH-1:0] read_or;
  logic [63:0]          back_w;
  logic [63:0]          read_w;
  logic [63:0]          front_w;
  logic [31:0]          count_w;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign op      = tfc_op_t'(in_operation);
  assign req_tag = TAG_WIDTH'(in_tag);
  assign tag_nz  = (req_tag != '0);
  assign full    = (count_r >= CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign pos_ok  = (PW'(in_position) < PW'(count_r));

  assign cmd.push   = accept && (op == OP_PUSH) && tag_nz && !full;
  assign cmd.pop    = accept && (op == OP_POP) && !empty;
  assign cmd.remove = accept && (op == OP_REMOVE) && tag_nz;

  assign hit[0] = 1'b0;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [TAG_WIDTH-1:0] nbr;
      if (gi == DEPTH - 1) begin : g_last
        assign nbr = cell_tag[gi];
      end else begin : g_mid
        assign nbr = cell_tag[gi+1];
      end
      tfc_cell #(
        .TAG_WIDTH (TAG_WIDTH),
        .CW        (CW),
        .PW        (PW),
        .IDX       (gi)
      ) u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .count     (count_r),
        .req_tag   (req_tag),
        .nbr_tag   (nbr),
        .hit_in    (hit[gi]),
        .hit_out   (hit[gi+1]),
        .rd_pos    (pos1_r),
        .tag       (cell_tag[gi]),
        .back_part (back_part[gi]),
        .read_part (read_part[gi])
      );
    end
  endgenerate

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_NOEFFECT;
    unique case (op)
      OP_PUSH: begin
        if (!tag_nz) begin
          status_nxt = ST_NOEFFECT;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_DONE;
          count_nxt  = count_r + CW'(1);
        end
      end
      OP_POP, OP_DROP: begin
        if (!empty) begin
          status_nxt = ST_DONE;
          count_nxt  = count_r - CW'(1);
        end
      end
      OP_REMOVE: begin
        if (hit[DEPTH]) begin
          status_nxt = ST_DONE;
          count_nxt  = count_r - CW'(1);
        end
      end
      OP_READ: begin
        status_nxt = pos_ok ? ST_DONE : ST_RANGE;
      end
      OP_FLUSH: begin
        status_nxt = ST_DONE;
        count_nxt  = '0;
      end
      default: begin
        status_nxt = ST_NOEFFECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      v1_r    <= 1'b0;
    end else begin
      v1_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status1_r <= status_nxt;
      rdok1_r   <= (op == OP_READ) && pos_ok;
      pos1_r    <= PW'(in_position);
    end
  end

  always_comb begin
    back_or = '0;
    read_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_or = back_or | back_part[i];
      read_or = read_or | read_part[i];
    end
  end

  assign back_w  = 64'(back_or);
  assign read_w  = rdok1_r ? 64'(read_or) : 64'd0;
  assign front_w = empty ? 64'd0 : 64'(cell_tag[0]);
  assign count_w = 32'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      out_status_r    <= status1_r;
      out_read_tag_r  <= read_w[31:0];
      out_front_tag_r <= front_w[31:0];
      out_back_tag_r  <= back_w[31:0];
      out_occupancy_r <= count_w[4:0];
      out_is_empty_r  <= empty;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_read_tag  = out_read_tag_r;
  assign out_front_tag = out_front_tag_r;
  assign out_back_tag  = out_back_tag_r;
  assign out_occupancy = out_occupancy_r;
  assign out_is_empty  = out_is_empty_r;

  `TFC_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(DEPTH), "entry count above depth")
  `TFC_ASSERT_NEXT(a_full_hold, accept && (op == OP_PUSH) && full, $stable(count_r),
                   "push to full queue changed count")
  `TFC_ASSERT_NEXT(a_flush_clear, accept && (op == OP_FLUSH), count_r == '0,
                   "flush left entries")
  `TFC_ASSERT_NOW(a_range_zero, out_valid_r && (out_status_r == ST_RANGE),
                  out_read_tag_r == 32'd0, "out of range read returned a tag")

endmodule

/* sv/tfc_cell.sv */
// One queue slot: holds a tag, loads on push, shifts from its neighbor on pop/remove.
// Depends on tfc_pkg.
`timescale 1ns / 1ps
module tfc_cell
  import tfc_pkg::*;
#(
  parameter int TAG_WIDTH = TAG_WIDTH_DEF,
  parameter int CW        = 5,
  parameter int PW        = 5,
  parameter int IDX       = 0
) (
  input  logic                 clk,
  input  tfc_cmd_t             cmd,
  input  logic [CW-1:0]        count,
  input  logic [TAG_WIDTH-1:0] req_tag,
  input  logic [TAG_WIDTH-1:0] nbr_tag,
  input  logic                 hit_in,
  output logic                 hit_out,
  input  logic [PW-1:0]        rd_pos,
  output logic [TAG_WIDTH-1:0] tag,
  output logic [TAG_WIDTH-1:0] back_part,
  output logic [TAG_WIDTH-1:0] read_part
);

  logic [TAG_WIDTH-1:0] tag_r;
  logic [TAG_WIDTH-1:0] tag_nxt;
  logic                 in_use;
  logic                 match;
  logic                 load;
  logic                 shift;
  logic                 back_sel;
  logic                 read_sel;

  assign in_use   = CW'(IDX) < count;
  assign match    = cmd.remove && in_use && (tag_r == req_tag);
  assign hit_out  = hit_in || match;
  assign load     = cmd.push && (CW'(IDX) == count);
  assign shift    = cmd.pop || hit_out;
  assign back_sel = (CW'(IDX + 1) == count);
  assign read_sel = (PW'(IDX) == rd_pos);

  always_comb begin
    priority if (load) begin
      tag_nxt = req_tag;
    end else if (shift) begin
      tag_nxt = nbr_tag;
    end else begin
      tag_nxt = tag_r;
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
  end

  assign tag       = tag_r;
  assign back_part = tag_r & {TAG_WIDTH{back_sel}};
  assign read_part = tag_r & {TAG_WIDTH{read_sel}};

endmodule
